@@ rtl/core/lruc_pkg.sv @@
package lruc_pkg;

  localparam int KEY_W         = 16;
  localparam int VAL_W         = 32;
  localparam int CAP_W         = 5;
  localparam int MAX_ENTRIES_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RST = 5'd16;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_PUT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

endpackage

@@ rtl/core/lruc_cell.sv @@
module lruc_cell #(
  parameter int IDX_W    = 4,
  parameter int OCC_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                        clk,
  input  logic                        upd,
  input  logic [IDX_W-1:0]            lim,
  input  logic [OCC_W-1:0]            occ,
  input  logic [lruc_pkg::KEY_W-1:0]  req_key,
  input  lruc_pkg::entry_t            prev_ent,
  output lruc_pkg::entry_t            ent,
  output logic                        match,
  output lruc_pkg::entry_t            drop
);
  import lruc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [OCC_W-1:0] MY_OCC = OCC_W'(CELL_IDX);

  entry_t ent_r;
  entry_t ent_nxt;
  logic   valid;

  // position in the chain is the recency rank, so the count of held entries
  // tells which cells are live
  assign valid = MY_OCC < occ;
  assign match = valid && (ent_r.key == req_key);
  assign drop  = (MY_IDX == lim) ? ent_r : '0;
  assign ent   = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (upd && (MY_IDX <= lim)) begin
      ent_nxt = prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ rtl/core/lru_key_value_cache.sv @@
// channel  | ports                                            | handshake
// ---------+--------------------------------------------------+---------------------------
// input    | in_action, in_key, in_value                      | start high, busy low
// result   | out_hit, out_read_value, out_evicted, out_evicted_key | out_valid, one cycle
// config   | cfg_wdata                                        | cfg_we
//
// an item passes the parallel key compare over the cell chain, then the shift that
// moves the touched entry to the front of the chain.
// the result strobe rises on the shift edge; a new item is taken on the shift edge
// itself, so it overlaps the shift of the last item, but none is taken during the
// compare, while busy is high.
// rst_n is synchronous and empties the store; capacity returns to 16.
// results cannot be stalled; each is shown for exactly one cycle.
module lru_key_value_cache #(
  parameter int MAX_ENTRIES = lruc_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_action,
  input  logic [lruc_pkg::KEY_W-1:0]  in_key,
  input  logic [lruc_pkg::VAL_W-1:0]  in_value,
  output logic                        out_valid,
  output logic                        out_hit,
  output logic [lruc_pkg::VAL_W-1:0]  out_read_value,
  output logic                        out_evicted,
  output logic [lruc_pkg::KEY_W-1:0]  out_evicted_key,
  input  logic                        cfg_we,
  input  logic [lruc_pkg::CAP_W-1:0]  cfg_wdata
);
  import lruc_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
  localparam int CW    = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  state_t state_r, state_nxt;
  logic   accept;

  logic [CAP_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r;

  logic             req_act_r;
  logic [KEY_W-1:0] req_key_r;
  logic [VAL_W-1:0] req_val_r;

  logic             hit_r, evict_r, upd_r, inc_r;
  logic [IDX_W-1:0] lim_r;

  logic             out_valid_r, out_hit_r, out_evicted_r;
  logic [VAL_W-1:0] out_read_value_r;
  logic [KEY_W-1:0] out_evicted_key_r;

  entry_t           chain_in  [MAX_ENTRIES];
  entry_t           chain_out [MAX_ENTRIES];
  entry_t           drop_v    [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] match_v;

  logic             any_hit;
  logic [IDX_W-1:0] hit_idx;
  logic [CW-1:0]    cap_ext, eff_cap;
  logic             full;
  entry_t           dropped;
  entry_t           front;
  logic             upd_now;

  assign busy   = (state_r == ST_CMP);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: state_nxt = accept ? ST_CMP : ST_IDLE;
      ST_CMP:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = accept ? ST_CMP : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_act_r <= in_action;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end
  end

  // cell chain: cell 0 is the most recent entry
  assign upd_now = (state_r == ST_UPD) && upd_r;

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign chain_in[g] = front;
    end else begin : g_link
      assign chain_in[g] = chain_out[g-1];
    end
    lruc_cell #(
      .IDX_W    (IDX_W),
      .OCC_W    (OCC_W),
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .upd      (upd_now),
      .lim      (lim_r),
      .occ      (occ_r),
      .req_key  (req_key_r),
      .prev_ent (chain_in[g]),
      .ent      (chain_out[g]),
      .match    (match_v[g]),
      .drop     (drop_v[g])
    );
  end

  // compare stage: keys are unique among live cells, so at most one match bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_v[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign any_hit = |match_v;
  assign cap_ext = CW'(cap_r);
  assign eff_cap = (cap_r == '0) ? CW'(1) :
                   (cap_ext > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cap_ext;
  assign full    = CW'(occ_r) >= eff_cap;

  always_ff @(posedge clk) begin
    if (state_r == ST_CMP) begin
      hit_r   <= any_hit;
      evict_r <= !any_hit && (req_act_r == ACT_PUT) && full;
      upd_r   <= any_hit || (req_act_r == ACT_PUT);
      inc_r   <= !any_hit && (req_act_r == ACT_PUT) && !full;
      if (any_hit) begin
        lim_r <= hit_idx;
      end else if (full) begin
        lim_r <= IDX_W'(occ_r - OCC_W'(1));
      end else begin
        lim_r <= IDX_W'(occ_r);
      end
    end
  end

  // update stage: the entry at the shift limit leaves its place
  always_comb begin
    dropped = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      dropped = dropped | drop_v[i];
    end
  end

  always_comb begin
    front.key   = req_key_r;
    front.value = req_val_r;
    if (hit_r && (req_act_r == ACT_GET)) begin
      front = dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else if (upd_now && inc_r) begin
      occ_r <= occ_r + OCC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      out_hit_r         <= hit_r;
      out_read_value_r  <= (hit_r && (req_act_r == ACT_GET)) ? dropped.value : '0;
      out_evicted_r     <= evict_r;
      out_evicted_key_r <= evict_r ? dropped.key : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

endmodule

@@ rtl/core/lruc_checker.sv @@
module lruc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        out_valid,
  input logic                        out_hit,
  input logic                        out_evicted,
  input logic [lruc_pkg::VAL_W-1:0]  out_read_value,
  input logic [lruc_pkg::KEY_W-1:0]  out_evicted_key
);
  import lruc_pkg::*;

  // every transfer in is followed by its result strobe
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##2 out_valid)
    else $error("result strobe missing after input transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after input transfer");

  a_no_double_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (!out_hit && out_read_value == '0))
    else $error("eviction reported on a hit");

  a_key_zero_unless_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_evicted_key == '0))
    else $error("evicted key set without eviction");

endmodule

bind lru_key_value_cache lruc_checker u_lruc_checker (.*);

@@ verif/lru_access_checker.sv @@
`timescale 1ns / 1ps

module lru_access_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  logic                       in_action,
  input  logic [lruc_pkg::KEY_W-1:0] in_key,
  input  logic [lruc_pkg::VAL_W-1:0] in_value,
  input  logic                       out_valid,
  input  logic                       out_hit,
  input  logic [lruc_pkg::VAL_W-1:0] out_read_value,
  input  logic                       out_evicted,
  input  logic [lruc_pkg::KEY_W-1:0] out_evicted_key,
  input  logic                       cfg_we,
  input  logic [lruc_pkg::CAP_W-1:0] cfg_wdata,
  output int                         fail_count,
  output int                         reply_backlog,
  output int                         access_total,
  output int                         hit_total,
  output int                         evict_total
);
  import lruc_pkg::*;

  localparam int SLOTS = MAX_ENTRIES_DEF;
  localparam int AGE_ALL = 32'h7fff_ffff;
  localparam int REPORT_LIMIT = 10;
  localparam int PEND_DEPTH = 4;
  localparam int PEND_IDX_W = 2;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } reply_t;

  logic [KEY_W-1:0] slot_key  [SLOTS];
  logic [VAL_W-1:0] slot_val  [SLOTS];
  logic             slot_live [SLOTS];
  int               slot_age  [SLOTS];
  int               live_count;
  logic [CAP_W-1:0] capacity;
  // predicted replies in transfer order
  reply_t           pend_reply [PEND_DEPTH];
  logic [PEND_IDX_W-1:0] pend_rd;
  logic [PEND_IDX_W-1:0] pend_wr;
  int               pend_count;
  int               mismatches_reported = 0;
  int               replies_seen = 0;

  function automatic int usable_capacity();
    int c;
    c = capacity;
    if (c < 1) c = 1;
    if (c > SLOTS) c = SLOTS;
    return c;
  endfunction

  // entries newer than limit age by one, slot s becomes the newest
  task automatic make_newest(input int s, input int limit);
    for (int i = 0; i < SLOTS; i++) begin
      if (i != s && slot_live[i] && slot_age[i] < limit) slot_age[i]++;
    end
    slot_age[s] = 0;
  endtask

  task automatic lookup_and_update(input logic act, input logic [KEY_W-1:0] k,
                                   input logic [VAL_W-1:0] v, output reply_t r);
    int found;
    int slot;
    int oldest;
    r = '0;
    found = -1;
    slot = -1;
    oldest = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (found < 0 && slot_live[i] && slot_key[i] == k) found = i;
    end
    if (found >= 0) begin
      r.hit = 1'b1;
      if (act == ACT_GET) r.read_value = slot_val[found];
      else slot_val[found] = v;
      make_newest(found, slot_age[found]);
    end else if (act == ACT_PUT) begin
      if (live_count >= usable_capacity()) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i] && (slot < 0 || slot_age[i] >= oldest)) begin
            slot = i;
            oldest = slot_age[i];
          end
        end
        if (slot >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[slot];
          slot_live[slot] = 1'b0;
          live_count--;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot < 0 && !slot_live[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        slot_key[slot] = k;
        slot_val[slot] = v;
        slot_live[slot] = 1'b1;
        live_count++;
        make_newest(slot, AGE_ALL);
      end
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t seen;
    reply_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_age[i] = 0;
      end
      live_count = 0;
      capacity = CAP_RST;
      pend_rd = '0;
      pend_wr = '0;
      pend_count = 0;
      fail_count <= 0;
      reply_backlog <= 0;
      access_total <= 0;
      hit_total <= 0;
      evict_total <= 0;
    end else begin
      if (cfg_we) capacity = cfg_wdata;
      if (out_valid) begin
        seen = {out_hit, out_read_value, out_evicted, out_evicted_key};
        replies_seen++;
        if (pend_count == 0) begin
          fail_count <= fail_count + 1;
          if (mismatches_reported < REPORT_LIMIT) begin
            $display("%0t: reply %0d unexpected: hit=%0b value=%h evicted=%0b key=%h",
                     $time, replies_seen, seen.hit, seen.read_value, seen.evicted,
                     seen.evicted_key);
          end
          mismatches_reported++;
        end else begin
          want = pend_reply[pend_rd];
          pend_rd = pend_rd + PEND_IDX_W'(1);
          pend_count--;
          if (seen.hit !== want.hit || seen.read_value !== want.read_value ||
              seen.evicted !== want.evicted || seen.evicted_key !== want.evicted_key) begin
            fail_count <= fail_count + 1;
            if (mismatches_reported < REPORT_LIMIT) begin
              $display("%0t: reply %0d expected hit=%0b value=%h evicted=%0b key=%h",
                       $time, replies_seen, want.hit, want.read_value, want.evicted,
                       want.evicted_key);
              $display("%0t: reply %0d actual   hit=%0b value=%h evicted=%0b key=%h",
                       $time, replies_seen, seen.hit, seen.read_value, seen.evicted,
                       seen.evicted_key);
            end
            mismatches_reported++;
          end
        end
      end
      if (start && !busy) begin
        lookup_and_update(in_action, in_key, in_value, fresh);
        if (pend_count < PEND_DEPTH) begin
          pend_reply[pend_wr] = fresh;
          pend_wr = pend_wr + PEND_IDX_W'(1);
          pend_count++;
        end else begin
          fail_count <= fail_count + 1;
          $display("%0t: too many transfers without a reply", $time);
        end
        access_total <= access_total + 1;
        hit_total <= hit_total + fresh.hit;
        evict_total <= evict_total + fresh.evicted;
      end
      reply_backlog <= pend_count;
    end
  end

endmodule

@@ verif/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps

module tb_lru_key_value_cache;
  import lruc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SEGMENT_ITEMS = 100;
  localparam int SETTLE_CYCLES = 8;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic             in_action;
  logic [KEY_W-1:0] in_key;
  logic [VAL_W-1:0] in_value;
  logic             out_valid;
  logic             out_hit;
  logic [VAL_W-1:0] out_read_value;
  logic             out_evicted;
  logic [KEY_W-1:0] out_evicted_key;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  int fail_count;
  int reply_backlog;
  int access_total;
  int hit_total;
  int evict_total;
  int sender_idle_pct = 0;
  int quiet_cycles = 0;
  int capacity_writes = 0;
  int pool_span = 4;
  int plan_caps [12];
  logic [KEY_W-1:0] pool_base = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lru_key_value_cache dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  lru_access_checker access_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .fail_count     (fail_count),
    .reply_backlog  (reply_backlog),
    .access_total   (access_total),
    .hit_total      (hit_total),
    .evict_total    (evict_total)
  );

  // returns at the edge where the request transfer happened, start still high
  task automatic issue_access(input logic act, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_key <= k;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (reply_backlog != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity_writes++;
  endtask

  task automatic random_access();
    int pick;
    logic act;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
    pick = $urandom_range(0, 99);
    act = ($urandom_range(0, 1) == 1) ? ACT_PUT : ACT_GET;
    // mostly a small key pool around the capacity so hits and evictions are common
    if (pick < 78) k = pool_base + KEY_W'($urandom_range(0, pool_span));
    else if (pick < 84) k = pick[0] ? '1 : '0;
    else k = KEY_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) v = '0;
    else if (pick < 10) v = '1;
    else v = $urandom;
    issue_access(act, k, v);
  endtask

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    int eff;
    rst_n = 1'b0;
    start = 1'b0;
    in_action = ACT_GET;
    in_key = '0;
    in_value = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    plan_caps = '{16, 1, 31, 4, 0, 2, 8, 17, 3, 16, 12, 5};
    plan_caps[10] = $urandom_range(0, 31);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, update, small and clamped capacities
    issue_access(ACT_GET, 16'h0000, 32'h0000_0000);
    issue_access(ACT_PUT, 16'h0000, 32'h0000_0000);
    issue_access(ACT_PUT, 16'hFFFF, 32'hFFFF_FFFF);
    issue_access(ACT_GET, 16'hFFFF, 32'h1234_5678);
    issue_access(ACT_PUT, 16'h0000, 32'hA5A5_5A5A);
    issue_access(ACT_GET, 16'h0000, 32'hFFFF_FFFF);
    write_capacity(5'd2);
    issue_access(ACT_PUT, 16'h5555, 32'h0000_0001);
    issue_access(ACT_GET, 16'hFFFF, 32'h0000_0000);
    // zero acts as one, and the two entries already held stay
    write_capacity(5'd0);
    issue_access(ACT_PUT, 16'h0001, 32'h0000_0003);
    issue_access(ACT_GET, 16'h5555, 32'h0000_0000);
    write_capacity(5'd31);
    for (int i = 0; i < 14; i++) issue_access(ACT_PUT, KEY_W'(16'h0100 + i), $urandom);
    issue_access(ACT_PUT, 16'h8000, 32'h8000_0000);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 58 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        write_capacity(CAP_W'(plan_caps[phase * 4 + seg]));
        eff = plan_caps[phase * 4 + seg];
        if (eff < 1) eff = 1;
        if (eff > MAX_ENTRIES_DEF) eff = MAX_ENTRIES_DEF;
        pool_base = KEY_W'($urandom);
        pool_span = eff + $urandom_range(0, 6);
        repeat (SEGMENT_ITEMS) random_access();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d accesses with %0d hits and %0d evictions", access_total,
             hit_total, evict_total);
    $display("over %0d capacity writes, sender idling at 36, 58 and 0 percent",
             capacity_writes);
    if (fail_count == 0 && reply_backlog == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
